// ===== sv/cxi_pkg.sv =====
// ============================================================================
// cxi_pkg
// Shared widths, register indexes, request types and the remainder step of
// the chunked XOR interleave codec.
// ============================================================================
package cxi_pkg;

  // Offset and chunk widths
  localparam int OFFSET_BITS = 24;
  localparam int CHUNK_BITS  = 17;

  // Width that holds any offset and any tail length without overflow
  localparam int WIDE_W = (OFFSET_BITS > CHUNK_BITS + 1) ? OFFSET_BITS : CHUNK_BITS + 1;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = (OFFSET_BITS > CHUNK_BITS) ? OFFSET_BITS : CHUNK_BITS;

  // Remainder cells, one per offset bit, then the finishing stages
  localparam int NUM_CELLS   = OFFSET_BITS;
  localparam int NUM_FINISH  = 5;

  // Register reset values
  localparam logic [CHUNK_BITS-1:0]  CHUNK_RESET = CHUNK_BITS'(32'd256);
  localparam logic [OFFSET_BITS-1:0] LIMIT_RESET = OFFSET_BITS'(32'd16777215);

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_DIRECTION  = 3'd0,
    CFG_FILE_SIZE  = 3'd1,
    CFG_CHUNK_SIZE = 3'd2,
    CFG_BYTE_LIMIT = 3'd3,
    CFG_KEY_START  = 3'd4,
    CFG_KEY_STEP   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]             data_byte;
    logic [OFFSET_BITS-1:0] byte_offset;
  } in_req_t;

  typedef struct packed {
    logic [7:0]             result_byte;
    logic [OFFSET_BITS-1:0] dest_offset;
    logic                   was_coded;
    logic                   offset_error;
  } out_rsp_t;

  // Current configuration; chunk holds the effective (nonzero) chunk size
  typedef struct packed {
    logic                   direction;
    logic [OFFSET_BITS-1:0] file_size;
    logic [CHUNK_BITS-1:0]  chunk;
    logic [OFFSET_BITS-1:0] byte_limit;
    logic [7:0]             key_start;
    logic [7:0]             key_step;
  } cfg_t;

  // Request moving down the remainder chain
  typedef struct packed {
    in_req_t                req;
    logic [OFFSET_BITS-1:0] off_sh;
    logic [CHUNK_BITS-1:0]  off_rem;
    logic [OFFSET_BITS-1:0] fs_sh;
    logic [CHUNK_BITS-1:0]  fs_rem;
  } div_t;

  // One restoring division step: shift in a dividend bit, subtract if it fits
  function automatic logic [CHUNK_BITS-1:0] rem_step(input logic [CHUNK_BITS-1:0] rem,
                                                     input logic                  din,
                                                     input logic [CHUNK_BITS-1:0] d);
    logic [CHUNK_BITS:0] t;
    logic [CHUNK_BITS:0] diff;
    t    = {rem, din};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      return diff[CHUNK_BITS-1:0];
    end else begin
      return t[CHUNK_BITS-1:0];
    end
  endfunction

endpackage

// ===== sv/cxi_div_cell.sv =====
// ============================================================================
// cxi_div_cell
// One cell of the remainder chain: advances the offset and file size
// remainders by one dividend bit and hands the request to the next cell.
// ============================================================================
module cxi_div_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic                           load_i,
  input  logic [cxi_pkg::CHUNK_BITS-1:0] divisor_i,
  input  cxi_pkg::div_t                  data_i,
  output logic                           valid_o,
  output cxi_pkg::div_t                  data_o
);
  import cxi_pkg::*;

  logic valid_q;
  div_t data_d;
  div_t data_q;

  // Step both remainders with the top bit of each dividend, then shift
  always_comb begin
    data_d         = data_i;
    data_d.off_rem = rem_step(data_i.off_rem, data_i.off_sh[OFFSET_BITS-1], divisor_i);
    data_d.fs_rem  = rem_step(data_i.fs_rem, data_i.fs_sh[OFFSET_BITS-1], divisor_i);
    data_d.off_sh  = data_i.off_sh << 1;
    data_d.fs_sh   = data_i.fs_sh << 1;
  end

  // Advance valid when the next stage can take it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= valid_i;
    end
  end

  // Capture payload
  always_ff @(posedge clk_i) begin
    if (load_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== sv/cxi_finish.sv =====
// ============================================================================
// cxi_finish
// Finishing stages: coded length, chunk bounds, permuted position and XOR
// key, with the last stage serving as the output register.
// ============================================================================
module cxi_finish (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cxi_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cxi_pkg::div_t     in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cxi_pkg::out_rsp_t out_data_o
);
  import cxi_pkg::*;

  typedef struct packed {
    logic [7:0]             data_byte;
    logic [OFFSET_BITS-1:0] off;
    logic                   err;
    logic [OFFSET_BITS-1:0] start;
    logic [CHUNK_BITS-1:0]  idx;
    logic [CHUNK_BITS:0]    tail;
  } st1_t;

  typedef struct packed {
    logic [7:0]             data_byte;
    logic [OFFSET_BITS-1:0] off;
    logic                   err;
    logic [OFFSET_BITS-1:0] start;
    logic [CHUNK_BITS-1:0]  idx;
    logic [OFFSET_BITS-1:0] coded_len;
  } st2_t;

  typedef struct packed {
    logic [7:0]             data_byte;
    logic [OFFSET_BITS-1:0] off;
    logic                   err;
    logic                   coded;
    logic [OFFSET_BITS-1:0] start;
    logic [CHUNK_BITS-1:0]  idx;
    logic [CHUNK_BITS-1:0]  len;
  } st3_t;

  typedef struct packed {
    logic [7:0]             data_byte;
    logic [OFFSET_BITS-1:0] off;
    logic                   err;
    logic                   coded;
    logic [OFFSET_BITS-1:0] start;
    logic [CHUNK_BITS-1:0]  idx;
    logic [CHUNK_BITS-1:0]  pos;
  } st4_t;

  logic     v1_q, v2_q, v3_q, v4_q, v5_q;
  logic     rdy1, rdy2, rdy3, rdy4, rdy5;
  st1_t     s1_d, s1_q;
  st2_t     s2_d, s2_q;
  st3_t     s3_d, s3_q;
  st4_t     s4_d, s4_q;
  out_rsp_t s5_d, s5_q;

  // Let each stage move when it is empty or the one after it moves
  assign rdy5       = !v5_q || out_ready_i;
  assign rdy4       = !v4_q || rdy5;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // Stage 1: range check, chunk start, position in chunk, tail length
  always_comb begin
    logic [CHUNK_BITS-1:0] quarter;
    logic [CHUNK_BITS-1:0] r_kept;
    quarter        = cfg_i.chunk >> 2;
    r_kept         = (in_data_i.fs_rem < quarter) ? in_data_i.fs_rem : '0;
    s1_d.data_byte = in_data_i.req.data_byte;
    s1_d.off       = in_data_i.req.byte_offset;
    s1_d.err       = in_data_i.req.byte_offset >= cfg_i.file_size;
    s1_d.start     = OFFSET_BITS'(WIDE_W'(in_data_i.req.byte_offset)
                                  - WIDE_W'(in_data_i.off_rem));
    s1_d.idx       = in_data_i.off_rem;
    s1_d.tail      = {1'b0, r_kept} + (CHUNK_BITS + 1)'(cfg_i.file_size[0]);
  end

  // Stage 2: coded length, zero when the tail exceeds the file
  always_comb begin
    s2_d.data_byte = s1_q.data_byte;
    s2_d.off       = s1_q.off;
    s2_d.err       = s1_q.err;
    s2_d.start     = s1_q.start;
    s2_d.idx       = s1_q.idx;
    if (WIDE_W'(s1_q.tail) > WIDE_W'(cfg_i.file_size)) begin
      s2_d.coded_len = '0;
    end else begin
      s2_d.coded_len = OFFSET_BITS'(WIDE_W'(cfg_i.file_size) - WIDE_W'(s1_q.tail));
    end
  end

  // Stage 3: decide coding, clip chunk length at the coded end
  always_comb begin
    logic [OFFSET_BITS-1:0] len_full;
    len_full       = s2_q.coded_len - s2_q.start;
    s3_d.data_byte = s2_q.data_byte;
    s3_d.off       = s2_q.off;
    s3_d.err       = s2_q.err;
    s3_d.start     = s2_q.start;
    s3_d.idx       = s2_q.idx;
    s3_d.coded     = !s2_q.err && (s2_q.off < s2_q.coded_len)
                     && (s2_q.start < cfg_i.byte_limit);
    if (WIDE_W'(len_full) > WIDE_W'(cfg_i.chunk)) begin
      s3_d.len = cfg_i.chunk;
    end else begin
      s3_d.len = CHUNK_BITS'(len_full);
    end
  end

  // Stage 4: permuted position inside the chunk
  always_comb begin
    logic [CHUNK_BITS:0]   half_w;
    logic [CHUNK_BITS-1:0] half;
    logic [CHUNK_BITS-1:0] two_i;
    logic [CHUNK_BITS-1:0] two_h;
    logic [CHUNK_BITS-1:0] rev_idx;
    logic [CHUNK_BITS-1:0] pos_dec;
    logic [CHUNK_BITS-1:0] pos_enc;
    half_w  = ({1'b0, s3_q.len} + (CHUNK_BITS + 1)'(1)) >> 1;
    half    = half_w[CHUNK_BITS-1:0];
    two_i   = {s3_q.idx[CHUNK_BITS-2:0], 1'b0};
    two_h   = {half[CHUNK_BITS-2:0], 1'b0};
    rev_idx = s3_q.len - CHUNK_BITS'(1) - s3_q.idx;
    if (s3_q.idx < half) begin
      pos_dec = s3_q.len - CHUNK_BITS'(1) - two_i;
    end else begin
      pos_dec = s3_q.len - CHUNK_BITS'(2) - two_i + two_h;
    end
    pos_enc = rev_idx[0] ? (half + (rev_idx >> 1)) : (rev_idx >> 1);
    s4_d.data_byte = s3_q.data_byte;
    s4_d.off       = s3_q.off;
    s4_d.err       = s3_q.err;
    s4_d.coded     = s3_q.coded;
    s4_d.start     = s3_q.start;
    s4_d.idx       = s3_q.idx;
    s4_d.pos       = cfg_i.direction ? pos_enc : pos_dec;
  end

  // Stage 5: key byte, XOR and destination; pass through when not coded
  always_comb begin
    logic [OFFSET_BITS-1:0] kpos_w;
    logic [OFFSET_BITS-1:0] pos_w;
    logic [7:0]             kidx;
    logic [15:0]            prod;
    logic [7:0]             key;
    kpos_w = OFFSET_BITS'(cfg_i.direction ? s4_q.pos : s4_q.idx);
    pos_w  = OFFSET_BITS'(s4_q.pos);
    kidx   = s4_q.start[7:0] + kpos_w[7:0];
    prod   = 16'(cfg_i.key_step) * 16'(kidx);
    key    = cfg_i.key_start + prod[7:0];
    s5_d.offset_error = s4_q.err;
    s5_d.was_coded    = s4_q.coded;
    if (s4_q.coded) begin
      s5_d.result_byte = s4_q.data_byte ^ key;
      s5_d.dest_offset = s4_q.start + pos_w;
    end else begin
      s5_d.result_byte = s4_q.data_byte;
      s5_d.dest_offset = s4_q.off;
    end
  end

  // Advance stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // Capture stage payloads
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) s1_q <= s1_d;
    if (rdy2 && v1_q)       s2_q <= s2_d;
    if (rdy3 && v2_q)       s3_q <= s3_d;
    if (rdy4 && v3_q)       s4_q <= s4_d;
    if (rdy5 && v4_q)       s5_q <= s5_d;
  end

  assign out_valid_o = v5_q;
  assign out_data_o  = s5_q;

endmodule

// ===== sv/chunked_xor_interleave_codec.sv =====
// ============================================================================
// chunked_xor_interleave_codec
// Byte-wise chunked XOR and interleave coder: maps each source byte and its
// offset to the coded byte and the offset where it belongs.
// ============================================================================
// Usage:
//   Configure through cfg_we_i / cfg_addr_i / cfg_wdata_i while no request is
//   in flight. Requests (data byte plus offset) enter on in_valid_i/in_ready_o;
//   results leave on out_valid_o/out_ready_i, one result per request, in order.
//   Each request passes one remainder cell per offset bit, computing offset
//   and file size modulo the chunk size, then five finishing stages for tail,
//   chunk bounds, position and key. Throughput is one request per cycle
//   while the receiver takes results; each stage holds one request.
//   When the receiver stalls, results back up stage by stage; empty stages
//   keep filling, so in_ready_o stays high while any stage has room and drops
//   only when every stage holds a request.
//   Reset clears all stage valids and loads the register defaults: decrypt,
//   file size 0, chunk size 256, no byte limit, key start and step 0.
//   A chunk size of 0 acts as 1. Offsets at or past the file size come back
//   unchanged with offset_error set.
// ============================================================================
module chunked_xor_interleave_codec (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cxi_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [cxi_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  cxi_pkg::in_req_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output cxi_pkg::out_rsp_t              out_data_o
);
  import cxi_pkg::*;

  logic                   direction_q;
  logic [OFFSET_BITS-1:0] file_size_q;
  logic [CHUNK_BITS-1:0]  chunk_size_q;
  logic [OFFSET_BITS-1:0] byte_limit_q;
  logic [7:0]             key_start_q;
  logic [7:0]             key_step_q;
  cfg_t                   cfg;

  logic                   cell_valid [NUM_CELLS];
  div_t                   cell_data  [NUM_CELLS];
  logic [NUM_CELLS:0]     cell_rdy;
  div_t                   head;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q  <= 1'b0;
      file_size_q  <= '0;
      chunk_size_q <= CHUNK_RESET;
      byte_limit_q <= LIMIT_RESET;
      key_start_q  <= '0;
      key_step_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_DIRECTION:  direction_q  <= cfg_wdata_i[0];
        CFG_FILE_SIZE:  file_size_q  <= cfg_wdata_i[OFFSET_BITS-1:0];
        CFG_CHUNK_SIZE: chunk_size_q <= cfg_wdata_i[CHUNK_BITS-1:0];
        CFG_BYTE_LIMIT: byte_limit_q <= cfg_wdata_i[OFFSET_BITS-1:0];
        CFG_KEY_START:  key_start_q  <= cfg_wdata_i[7:0];
        CFG_KEY_STEP:   key_step_q   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Bundle configuration; treat a zero chunk size as one
  always_comb begin
    cfg.direction  = direction_q;
    cfg.file_size  = file_size_q;
    cfg.chunk      = (chunk_size_q == '0) ? CHUNK_BITS'(1) : chunk_size_q;
    cfg.byte_limit = byte_limit_q;
    cfg.key_start  = key_start_q;
    cfg.key_step   = key_step_q;
  end

  // Seed the chain with both dividends and zero remainders
  always_comb begin
    head.req     = in_data_i;
    head.off_sh  = in_data_i.byte_offset;
    head.off_rem = '0;
    head.fs_sh   = file_size_q;
    head.fs_rem  = '0;
  end

  // Let a cell move when it is empty or its successor moves
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_rdy
    assign cell_rdy[k] = !cell_valid[k] || cell_rdy[k+1];
  end
  assign in_ready_o = cell_rdy[0];

  // Remainder chain
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    if (k == 0) begin : g_first
      cxi_div_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .valid_i   (in_valid_i),
        .load_i    (cell_rdy[k]),
        .divisor_i (cfg.chunk),
        .data_i    (head),
        .valid_o   (cell_valid[k]),
        .data_o    (cell_data[k])
      );
    end else begin : g_next
      cxi_div_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .valid_i   (cell_valid[k-1]),
        .load_i    (cell_rdy[k]),
        .divisor_i (cfg.chunk),
        .data_i    (cell_data[k-1]),
        .valid_o   (cell_valid[k]),
        .data_o    (cell_data[k])
      );
    end
  end

  // Finishing stages and output register
  cxi_finish u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (cell_valid[NUM_CELLS-1]),
    .in_ready_o  (cell_rdy[NUM_CELLS]),
    .in_data_i   (cell_data[NUM_CELLS-1]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sv/cxi_checker.sv =====
// ============================================================================
// cxi_checker
// Port-level checks on the chunked XOR interleave codec, bound to the top.
// ============================================================================
module cxi_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input cxi_pkg::out_rsp_t out_data_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // Drop the output while reset is active
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result shown during reset");

  // Take requests whenever the output side has room
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("request refused with free output");

  // Never mark an out-of-range byte as coded
  a_err_uncoded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.offset_error |-> !out_data_o.was_coded)
    else $error("out-of-range byte was coded");

endmodule

bind chunked_xor_interleave_codec cxi_checker u_cxi_checker (.*);
